// ----- design/avfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avfd_pkg
// Shared types and constants of the ASCII id/value frame decoder.
// ----------------------------------------------------------------------------
package avfd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned MANT_W = 64;
   localparam int unsigned CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_START  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_START = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERMINATOR   = 8'd3;

   localparam logic [BYTE_W-1:0] RST_FIRST_START  = 8'h23;
   localparam logic [BYTE_W-1:0] RST_SECOND_START = 8'h50;
   localparam logic [BYTE_W-1:0] RST_SEPARATOR    = 8'h3D;
   localparam logic [BYTE_W-1:0] RST_TERMINATOR   = 8'h21;

   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;

   localparam logic [BYTE_W-1:0] FRAC_MAX = 8'd255;

   typedef struct packed {
      logic [BYTE_W-1:0] first_start;
      logic [BYTE_W-1:0] second_start;
      logic [BYTE_W-1:0] separator;
      logic [BYTE_W-1:0] terminator;
   } avfd_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]        frame_id;
      logic                     is_negative;
      logic signed [MANT_W-1:0] mantissa;
      logic [BYTE_W-1:0]        fraction_digits;
      logic [BYTE_W-1:0]        payload_length;
      logic                     overflow;
   } avfd_result_type;

endpackage
`default_nettype wire

// ----- design/ascii_id_value_frame_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_id_value_frame_decoder
// A result appears on rsp_ in the cycle after its terminator byte is taken.
// Throughput: one byte per cycle while req_stall is low; the Horner step is combinational.
// Input stalls only when a terminator meets a full, stalled result register.
// Reset: synchronous; restores default markers and waits for a first start.
// ----------------------------------------------------------------------------
module ascii_id_value_frame_decoder #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [avfd_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [avfd_pkg::BYTE_W-1:0]             rsp_frame_id,
   output logic                                    rsp_is_negative,
   output logic signed [avfd_pkg::MANT_W-1:0]      rsp_mantissa,
   output logic [avfd_pkg::BYTE_W-1:0]             rsp_fraction_digits,
   output logic [avfd_pkg::BYTE_W-1:0]             rsp_payload_length,
   output logic                                    rsp_overflow,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [avfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [avfd_pkg::BYTE_W-1:0]        csr_wdata
);
   import avfd_pkg::*;

   avfd_cfg_type    cfg;
   avfd_result_type result;
   avfd_result_type rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            term_hit;
   logic            fire;
   logic            take;

   assign req_stall = rsp_valid_ff && rsp_stall && term_hit;
   assign take      = req_valid && !req_stall;

   avfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   avfd_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .rx_byte  (req_rx_byte),
      .cfg      (cfg),
      .term_hit (term_hit),
      .fire     (fire),
      .result   (result)
   );

   // load on terminator, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_id        = rsp_data_ff.frame_id;
   assign rsp_is_negative     = rsp_data_ff.is_negative;
   assign rsp_mantissa        = rsp_data_ff.mantissa;
   assign rsp_fraction_digits = rsp_data_ff.fraction_digits;
   assign rsp_payload_length  = rsp_data_ff.payload_length;
   assign rsp_overflow        = rsp_data_ff.overflow;

endmodule
`default_nettype wire

// ----- design/avfd_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avfd_csr
// Marker byte registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module avfd_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [avfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [avfd_pkg::BYTE_W-1:0]         csr_wdata,
   output avfd_pkg::avfd_cfg_type                   cfg
);
   import avfd_pkg::*;

   avfd_cfg_type cfg_ff;
   avfd_cfg_type cfg_in;
   logic         wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            CSR_FIRST_START:  cfg_in.first_start  = csr_wdata;
            CSR_SECOND_START: cfg_in.second_start = csr_wdata;
            CSR_SEPARATOR:    cfg_in.separator    = csr_wdata;
            CSR_TERMINATOR:   cfg_in.terminator   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_start  <= RST_FIRST_START;
         cfg_ff.second_start <= RST_SECOND_START;
         cfg_ff.separator    <= RST_SEPARATOR;
         cfg_ff.terminator   <= RST_TERMINATOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/avfd_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avfd_parser
// Frame phase tracking and on-the-fly Horner conversion of the payload.
// ----------------------------------------------------------------------------
module avfd_parser #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [avfd_pkg::BYTE_W-1:0]   rx_byte,
   input  wire avfd_pkg::avfd_cfg_type        cfg,
   output logic                               term_hit,
   output logic                               fire,
   output avfd_pkg::avfd_result_type          result
);
   import avfd_pkg::*;

   localparam logic [2:0] PH_FIRST   = 3'd0;
   localparam logic [2:0] PH_SECOND  = 3'd1;
   localparam logic [2:0] PH_ID      = 3'd2;
   localparam logic [2:0] PH_SEP     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

   localparam logic signed [MANT_W-1:0] S64_MAX = {1'b0, {(MANT_W-1){1'b1}}};
   localparam logic signed [MANT_W-1:0] S64_MIN = {1'b1, {(MANT_W-1){1'b0}}};
   localparam logic signed [MANT_W-1:0] PRE_HI  = 64'sd922337203685477580;
   localparam logic signed [MANT_W-1:0] PRE_LO  = -64'sd922337203685477580;
   localparam logic signed [MANT_W+3:0] WIDE_MAX = {4'b0000, S64_MAX};
   localparam logic signed [MANT_W+3:0] WIDE_MIN = {4'b1111, S64_MIN};

   logic [2:0]               phase_ff, phase_in;
   logic [BYTE_W-1:0]        id_ff, id_in;
   logic signed [MANT_W-1:0] mant_ff, mant_in;
   logic [BYTE_W-1:0]        frac_ff, frac_in;
   logic                     point_ff, point_in;
   logic                     minus_ff, minus_in;
   logic [BYTE_W-1:0]        count_ff, count_in;
   logic                     ovf_ff, ovf_in;

   logic signed [8:0]        digit;
   logic signed [MANT_W+3:0] mant_wide;
   logic signed [MANT_W+3:0] sum;
   logic signed [MANT_W-1:0] horner_val;
   logic                     horner_ovf;

   assign term_hit = (phase_ff == PH_PAYLOAD) && (rx_byte == cfg.terminator);
   assign fire     = take && term_hit;

   assign result.frame_id        = id_ff;
   assign result.is_negative     = minus_ff;
   assign result.mantissa        = mant_ff;
   assign result.fraction_digits = frac_ff;
   assign result.payload_length  = count_ff;
   assign result.overflow        = ovf_ff;

   assign digit     = $signed({1'b0, rx_byte}) - $signed({1'b0, CH_ZERO});
   assign mant_wide = {{4{mant_ff[MANT_W-1]}}, mant_ff};
   assign sum       = (mant_wide <<< 3) + (mant_wide <<< 1)
                      + {{(MANT_W-5){digit[8]}}, digit};

   always_comb begin
      horner_ovf = 1'b1;
      priority if (mant_ff > PRE_HI) begin
         horner_val = S64_MAX;
      end else if (mant_ff < PRE_LO) begin
         horner_val = S64_MIN;
      end else if (sum > WIDE_MAX) begin
         horner_val = S64_MAX;
      end else if (sum < WIDE_MIN) begin
         horner_val = S64_MIN;
      end else begin
         horner_val = sum[MANT_W-1:0];
         horner_ovf = 1'b0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      id_in    = id_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      point_in = point_ff;
      minus_in = minus_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (take) begin
         unique case (phase_ff)
            PH_SECOND: begin
               if (rx_byte == cfg.second_start) phase_in = PH_ID;
            end
            PH_ID: begin
               id_in    = rx_byte - CH_ZERO;
               phase_in = PH_SEP;
            end
            PH_SEP: begin
               if (rx_byte == cfg.separator) phase_in = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               priority if (term_hit) begin
                  phase_in = PH_FIRST;
                  mant_in  = '0;
                  frac_in  = '0;
                  point_in = 1'b0;
                  minus_in = 1'b0;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else if (count_ff >= MAX_LEN) begin
                  ovf_in = 1'b1;
               end else if (rx_byte == CH_MINUS) begin
                  count_in = count_ff + 1'b1;
                  minus_in = 1'b1;
               end else if (!point_ff && rx_byte == CH_POINT) begin
                  count_in = count_ff + 1'b1;
                  point_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
                  mant_in  = horner_val;
                  ovf_in   = ovf_ff || horner_ovf;
                  if (point_ff && frac_ff < FRAC_MAX) frac_in = frac_ff + 1'b1;
               end
            end
            default: begin
               phase_in = (rx_byte == cfg.first_start) ? PH_SECOND : PH_FIRST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         id_ff    <= '0;
         mant_ff  <= '0;
         frac_ff  <= '0;
         point_ff <= 1'b0;
         minus_ff <= 1'b0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         id_ff    <= id_in;
         mant_ff  <= mant_in;
         frac_ff  <= frac_in;
         point_ff <= point_in;
         minus_ff <= minus_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule
`default_nettype wire

// ----- tb/avfd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// avfd_frame_checker
// Watches the byte, result and register channels of the frame decoder. Keeps
// its own copy of the markers and of the frame parser, works out the value of
// every terminated frame, and compares each result against the oldest value
// still awaited. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module avfd_frame_checker #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_stall,
   input  wire logic [avfd_pkg::BYTE_W-1:0]        req_rx_byte,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  wire logic [avfd_pkg::BYTE_W-1:0]        rsp_frame_id,
   input  wire logic                               rsp_is_negative,
   input  wire logic signed [avfd_pkg::MANT_W-1:0] rsp_mantissa,
   input  wire logic [avfd_pkg::BYTE_W-1:0]        rsp_fraction_digits,
   input  wire logic [avfd_pkg::BYTE_W-1:0]        rsp_payload_length,
   input  wire logic                               rsp_overflow,
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic [avfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [avfd_pkg::BYTE_W-1:0]        csr_wdata,
   output int unsigned                             errors,
   output int unsigned                             outstanding
);
   import avfd_pkg::*;

   typedef enum logic [2:0] {
      SCAN_FIRST, SCAN_SECOND, TAKE_ID, SCAN_SEP, IN_PAYLOAD
   } scan_phase_type;

   localparam int RADIX = 10;
   localparam longint MANT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint MANT_MIN = 64'sh8000_0000_0000_0000;
   localparam longint MANT_MAX_TENTH = MANT_MAX / RADIX;
   localparam longint MANT_MIN_TENTH = MANT_MIN / RADIX;
   localparam int unsigned REPORT_LINES = 100;

   avfd_cfg_type      markers;
   scan_phase_type    phase;
   logic [BYTE_W-1:0] id_hold;
   logic [BYTE_W-1:0] frac_count;
   logic [BYTE_W-1:0] len_count;
   longint            acc;
   bit                point_seen;
   bit                minus_seen;
   bit                ovf_seen;
   avfd_result_type   frame_values_q[$];

   function automatic void clear_value();
      acc = 0;
      frac_count = '0;
      len_count = '0;
      point_seen = 1'b0;
      minus_seen = 1'b0;
      ovf_seen = 1'b0;
   endfunction

   // advance the parser by one byte; returns 1 with the frame value on a terminator
   function automatic bit decode_byte(input logic [BYTE_W-1:0] b,
                                      output avfd_result_type value);
      int     digit;
      longint prod;
      value = '0;
      decode_byte = 1'b0;
      case (phase)
         SCAN_SECOND: begin
            if (b == markers.second_start) phase = TAKE_ID;
         end
         TAKE_ID: begin
            id_hold = b - CH_ZERO;
            phase = SCAN_SEP;
         end
         SCAN_SEP: begin
            if (b == markers.separator) phase = IN_PAYLOAD;
         end
         IN_PAYLOAD: begin
            if (b == markers.terminator) begin
               value.frame_id = id_hold;
               value.is_negative = minus_seen;
               value.mantissa = acc;
               value.fraction_digits = frac_count;
               value.payload_length = len_count;
               value.overflow = ovf_seen;
               clear_value();
               phase = SCAN_FIRST;
               decode_byte = 1'b1;
            end else if (len_count >= MAX_PAYLOAD) begin
               ovf_seen = 1'b1;
            end else begin
               len_count++;
               if (b == CH_MINUS) begin
                  minus_seen = 1'b1;
               end else if (!point_seen && b == CH_POINT) begin
                  point_seen = 1'b1;
               end else begin
                  digit = int'(b) - int'(CH_ZERO);
                  if (acc > MANT_MAX_TENTH) begin
                     acc = MANT_MAX;
                     ovf_seen = 1'b1;
                  end else if (acc < MANT_MIN_TENTH) begin
                     acc = MANT_MIN;
                     ovf_seen = 1'b1;
                  end else begin
                     prod = acc * RADIX;
                     if (digit > 0 && prod > MANT_MAX - digit) begin
                        acc = MANT_MAX;
                        ovf_seen = 1'b1;
                     end else if (digit < 0 && prod < MANT_MIN - digit) begin
                        acc = MANT_MIN;
                        ovf_seen = 1'b1;
                     end else begin
                        acc = prod + digit;
                     end
                  end
                  if (point_seen && frac_count < FRAC_MAX) frac_count++;
               end
            end
         end
         default: begin
            phase = (b == markers.first_start) ? SCAN_SECOND : SCAN_FIRST;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (errors < REPORT_LINES)
         $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin : watch_channels
      avfd_result_type got;
      avfd_result_type want;
      if (reset) begin
         markers = '{first_start: RST_FIRST_START, second_start: RST_SECOND_START,
                     separator: RST_SEPARATOR, terminator: RST_TERMINATOR};
         phase = SCAN_FIRST;
         id_hold = '0;
         clear_value();
         frame_values_q.delete();
         errors = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.frame_id = rsp_frame_id;
            got.is_negative = rsp_is_negative;
            got.mantissa = rsp_mantissa;
            got.fraction_digits = rsp_fraction_digits;
            got.payload_length = rsp_payload_length;
            got.overflow = rsp_overflow;
            if (frame_values_q.size() == 0) begin
               report_mismatch("result with none awaited, frame_id", 64'(got.frame_id), '0);
            end else begin
               want = frame_values_q.pop_front();
               if (got.frame_id !== want.frame_id)
                  report_mismatch("frame_id", 64'(got.frame_id), 64'(want.frame_id));
               if (got.is_negative !== want.is_negative)
                  report_mismatch("is_negative", 64'(got.is_negative),
                                  64'(want.is_negative));
               if (got.mantissa !== want.mantissa)
                  report_mismatch("mantissa", got.mantissa, want.mantissa);
               if (got.fraction_digits !== want.fraction_digits)
                  report_mismatch("fraction_digits", 64'(got.fraction_digits),
                                  64'(want.fraction_digits));
               if (got.payload_length !== want.payload_length)
                  report_mismatch("payload_length", 64'(got.payload_length),
                                  64'(want.payload_length));
               if (got.overflow !== want.overflow)
                  report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_START:  markers.first_start = csr_wdata;
               CSR_SECOND_START: markers.second_start = csr_wdata;
               CSR_SEPARATOR:    markers.separator = csr_wdata;
               CSR_TERMINATOR:   markers.terminator = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall && decode_byte(req_rx_byte, want))
            frame_values_q.push_back(want);
         outstanding <= frame_values_q.size();
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ASCII id/value frame decoder. Sends directed
// frames, then random well-formed frames with random payloads mixed with
// noise and broken frames, under three marker settings and three patterns of
// idle and stall. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import avfd_pkg::*;

   localparam int unsigned MAX_PAYLOAD = 128;
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 5;
   localparam int SETTLE_CYCLES = 4;
   localparam int unsigned PHASE_BYTES = 120;
   localparam int TIMEOUT_NS = 2_400_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_LAST = '1;

   typedef enum int {PL_MIX, PL_RISE, PL_FALL, PL_ZEROS} payload_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0] csr_wdata = '0;

   logic req_stall;
   logic rsp_valid;
   logic [BYTE_W-1:0] rsp_frame_id;
   logic rsp_is_negative;
   logic signed [MANT_W-1:0] rsp_mantissa;
   logic [BYTE_W-1:0] rsp_fraction_digits;
   logic [BYTE_W-1:0] rsp_payload_length;
   logic rsp_overflow;
   logic csr_ready;

   int unsigned mismatch_count;
   int unsigned pending_results;
   int unsigned send_idle_pct = 15;
   int unsigned recv_stall_pct = 73;
   int unsigned bytes_sent = 0;
   avfd_cfg_type markers = '{first_start: RST_FIRST_START, second_start: RST_SECOND_START,
                             separator: RST_SEPARATOR, terminator: RST_TERMINATOR};

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   ascii_id_value_frame_decoder #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_frame_id(rsp_frame_id),
      .rsp_is_negative(rsp_is_negative), .rsp_mantissa(rsp_mantissa),
      .rsp_fraction_digits(rsp_fraction_digits), .rsp_payload_length(rsp_payload_length),
      .rsp_overflow(rsp_overflow),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   avfd_frame_checker #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_frame_id(rsp_frame_id),
      .rsp_is_negative(rsp_is_negative), .rsp_mantissa(rsp_mantissa),
      .rsp_fraction_digits(rsp_fraction_digits), .rsp_payload_length(rsp_payload_length),
      .rsp_overflow(rsp_overflow),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .errors(mismatch_count), .outstanding(pending_results)
   );

   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // hold off until every awaited result is out, then let the block settle
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FIRST_START:  markers.first_start = val;
         CSR_SECOND_START: markers.second_start = val;
         CSR_SEPARATOR:    markers.separator = val;
         CSR_TERMINATOR:   markers.terminator = val;
         default: ;
      endcase
   endtask

   function automatic logic [BYTE_W-1:0] pick_payload_byte(input payload_style_type style);
      logic [BYTE_W-1:0] b;
      int unsigned r;
      r = $urandom_range(99);
      case (style)
         PL_MIX: begin
            if (r < 65) b = CH_ZERO + BYTE_W'($urandom_range(9));
            else if (r < 75) b = CH_MINUS;
            else if (r < 87) b = CH_POINT;
            else b = BYTE_W'($urandom_range(255));
         end
         PL_RISE: b = CH_ZERO + BYTE_W'($urandom_range(9, 1));
         PL_FALL: b = BYTE_W'($urandom_range(CH_MINUS - 1));
         default: b = CH_ZERO;
      endcase
      while (b == markers.terminator) b = BYTE_W'($urandom_range(255));
      return b;
   endfunction

   task automatic send_frame(input int unsigned len, input payload_style_type style,
                             input bit terminate);
      if ($urandom_range(3) == 0) send_byte(BYTE_W'($urandom_range(255)));
      send_byte(markers.first_start);
      if ($urandom_range(7) == 0) send_byte(BYTE_W'($urandom_range(255)));
      send_byte(markers.second_start);
      send_byte(BYTE_W'($urandom_range(255)));
      if ($urandom_range(7) == 0) send_byte(BYTE_W'($urandom_range(255)));
      send_byte(markers.separator);
      repeat (len) send_byte(pick_payload_byte(style));
      if (terminate) send_byte(markers.terminator);
   endtask

   task automatic run_random(input int unsigned budget, input bit with_long);
      int unsigned stop_at;
      int unsigned r;
      int long_at;
      int frame_no;
      stop_at = bytes_sent + budget;
      long_at = with_long ? int'($urandom_range(4, 1)) : -1;
      frame_no = 0;
      while (bytes_sent < stop_at) begin
         r = $urandom_range(99);
         if (frame_no == long_at)
            send_frame(MAX_PAYLOAD + $urandom_range(3, 1), PL_ZEROS, 1'b1);
         else if (r < 65)
            send_frame($urandom_range(10), PL_MIX, $urandom_range(19) != 0);
         else if (r < 77)
            send_frame($urandom_range(24, 19), PL_RISE, 1'b1);
         else if (r < 89)
            send_frame($urandom_range(24, 19), PL_FALL, 1'b1);
         else
            repeat ($urandom_range(6, 1)) send_byte(BYTE_W'($urandom_range(255)));
         frame_no++;
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("#P5=-3.14!");
      send_text("x#yP#q=1.2.!");
      send_text("#P");
      send_byte(8'hFF);
      send_text("=");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("!#P9=!");
      // change the terminator in the middle of a payload
      send_text("#P7=4");
      wait_drain();
      write_reg(CSR_TERMINATOR, "Z");
      csr_valid <= 1'b0;
      send_text("2!Z");
      wait_drain();
      write_reg(CSR_TERMINATOR, RST_TERMINATOR);
      csr_valid <= 1'b0;

      // just above the largest mantissa that can take one more digit
      send_text("#P0=922337203685477581");
      send_byte(pick_payload_byte(PL_FALL));
      send_text("!");
      run_random(PHASE_BYTES, 1'b0);
      wait_drain();

      write_reg(CSR_FIRST_START, 8'h00);
      write_reg(CSR_SECOND_START, 8'hFF);
      write_reg(CSR_SEPARATOR, 8'h00);
      write_reg(CSR_TERMINATOR, 8'hFF);
      write_reg(CSR_INDEX_W'($urandom_range(CSR_INDEX_LAST, CSR_TERMINATOR + 1)),
                BYTE_W'($urandom_range(255)));
      write_reg(CSR_INDEX_LAST, BYTE_W'($urandom_range(255)));
      csr_valid <= 1'b0;
      send_idle_pct = 73;
      recv_stall_pct = 15;
      run_random(PHASE_BYTES, 1'b1);
      wait_drain();

      write_reg(CSR_FIRST_START, BYTE_W'($urandom_range(255)));
      write_reg(CSR_SECOND_START, BYTE_W'($urandom_range(255)));
      write_reg(CSR_SEPARATOR, BYTE_W'($urandom_range(255)));
      write_reg(CSR_TERMINATOR, BYTE_W'($urandom_range(255)));
      csr_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_random(PHASE_BYTES, 1'b0);
      wait_drain();

      if (mismatch_count == 0 && pending_results == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
